@@ rtl/ccsd_pkg.sv @@
`default_nettype none
package ccsd_pkg;

	localparam int WORD_BITS  = 24;
	localparam int GUARD_BITS = 2;

	// differences of two words, their products and sums of three products
	localparam int DIFF_W = WORD_BITS + 1;
	localparam int SQ_W   = 2 * WORD_BITS + 2;
	localparam int HALF_W = SQ_W / 2;
	localparam int PROD_W = 2 * SQ_W;

	// divider: numerator scaled by 2^(2G), quotient bounded by 2^QUO_W
	localparam int QUO_W = SQ_W + 2 * GUARD_BITS;
	localparam int NUM_W = PROD_W + 2 * GUARD_BITS;

	// square root: radicand of RAD_W bits, one root bit per cell
	localparam int ROOT_W = (QUO_W + 1) / 2 + 1;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int DIST_W = ROOT_W + 2;

	localparam int FRONT_STAGES = 6;
	localparam int SIDE_A_LEN   = QUO_W + ROOT_W + 1;
	localparam int N_STAGES     = FRONT_STAGES + QUO_W + 2 * ROOT_W + 2;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] point_x;
		logic signed [WORD_BITS-1:0] point_y;
		logic signed [WORD_BITS-1:0] point_z;
		logic signed [WORD_BITS-1:0] end_a_x;
		logic signed [WORD_BITS-1:0] end_a_y;
		logic signed [WORD_BITS-1:0] end_a_z;
		logic signed [WORD_BITS-1:0] end_b_x;
		logic signed [WORD_BITS-1:0] end_b_y;
		logic signed [WORD_BITS-1:0] end_b_z;
		logic [WORD_BITS-2:0]        radius;
	} in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] distance;
		logic                        degenerate;
		logic                        saturated;
	} out_t;

	typedef struct packed {
		logic [SQ_W-1:0]  rem;
		logic [QUO_W-1:0] w;
		logic [SQ_W-1:0]  d;
	} div_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  w;
	} sqrt_t;

	typedef struct packed {
		logic [WORD_BITS-2:0] radius;
		logic                 ypos;
		logic                 degen;
	} sida_t;

	typedef struct packed {
		logic                     bneg;
		logic signed [DIST_W-1:0] dmax;
		logic                     degen;
	} sidb_t;

endpackage
`default_nettype wire

@@ rtl/ccsd_div_cell.sv @@
`default_nettype none
// one restoring division step: one quotient bit enters w as one numerator bit leaves
module ccsd_div_cell (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire ccsd_pkg::div_t din,
	output ccsd_pkg::div_t      dout
);
	import ccsd_pkg::*;

	logic [SQ_W:0] trial;
	logic [SQ_W:0] diff;
	logic          ge;

	assign trial = {din.rem, din.w[QUO_W-1]};
	assign diff  = trial - {1'b0, din.d};
	assign ge    = (trial >= {1'b0, din.d});

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
			dout.w   <= {din.w[QUO_W-2:0], ge};
			dout.d   <= din.d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ccsd_sqrt_cell.sv @@
`default_nettype none
// one digit of the integer square root: two radicand bits in, one root bit out
module ccsd_sqrt_cell (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire ccsd_pkg::sqrt_t din,
	output ccsd_pkg::sqrt_t      dout
);
	import ccsd_pkg::*;

	logic [REM_W+1:0] acc;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	assign acc   = {din.rem, din.w[RAD_W-1 -: 2]};
	assign trial = {2'b00, din.root, 2'b01};
	assign diff  = acc - trial;
	assign ge    = (acc >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem  <= ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
			dout.root <= {din.root[ROOT_W-2:0], ge};
			dout.w    <= {din.w[RAD_W-3:0], 2'b00};
		end
	end

endmodule
`default_nettype wire

@@ rtl/capped_cylinder_signed_distance.sv @@
`default_nettype none
// Capped cylinder signed distance, fully pipelined.
// Input channel in_valid/in_ready/in_data carries the query point, both axis
// end points and the radius (Q12.12). Output channel out_valid/out_ready/
// out_data carries the distance (negative inside), a flag for coincident end
// points and a flag for a clamped distance.
// Throughput: one transaction per cycle while the receiver does not stall.
// The depth is set by the cell chains: a row of 54 restoring divider cells
// (one quotient bit each) feeding a row of 28 square root cells, and a second
// row of 28 root cells for the final distance.
// Radial and axial terms travel in two parallel rows.
// Output holds a register plus a skid register. When the receiver stalls,
// one more result lands in the skid register and then in_ready drops and the
// whole pipeline freezes until the skid register empties.
// Reset (arst_n low) clears all valid bits but not the output data or its flags; no
// transaction is lost or duplicated across a stall.
module capped_cylinder_signed_distance (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ccsd_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ccsd_pkg::out_t      out_data
);
	import ccsd_pkg::*;

	function automatic logic [PROD_W-1:0] sum4(input logic [SQ_W-1:0] hh,
		input logic [SQ_W-1:0] hl, input logic [SQ_W-1:0] lh, input logic [SQ_W-1:0] ll);
		logic [PROD_W-1:0] mid;
		mid = PROD_W'(hl) + PROD_W'(lh);
		return {hh, {SQ_W{1'b0}}} + (mid << HALF_W) + PROD_W'(ll);
	endfunction

	localparam logic signed [DIST_W:0] D_HI = (DIST_W+1)'((2**(WORD_BITS-1)) - 1);
	localparam logic signed [DIST_W:0] D_LO = (DIST_W+1)'(-(2**(WORD_BITS-1)));

	logic en;
	logic [N_STAGES-1:0] vld_q;
	logic ov_q, sv_q;
	out_t oq_q, sq_q, res;

	assign en       = !sv_q;
	assign in_ready = !sv_q;
	assign out_valid = ov_q;
	assign out_data  = oq_q;

	// ---------------- front end ----------------
	logic signed [WORD_BITS-1:0] px [3], ax [3], bx [3];
	assign px[0] = in_data.point_x; assign px[1] = in_data.point_y;
	assign px[2] = in_data.point_z;
	assign ax[0] = in_data.end_a_x; assign ax[1] = in_data.end_a_y;
	assign ax[2] = in_data.end_a_z;
	assign bx[0] = in_data.end_b_x; assign bx[1] = in_data.end_b_y;
	assign bx[2] = in_data.end_b_z;

	logic signed [DIFF_W-1:0] pa_s1 [3], ba_s1 [3];
	logic signed [SQ_W-1:0]   pp_s2 [3], ll_s2 [3], pb_s2 [3];
	logic [SQ_W-1:0]          pp_s3, ll_s3, tm_s3;
	logic                     tneg_s3;
	logic [SQ_W-1:0]          lp_s4 [4], tt_s4 [4];
	logic [SQ_W-1:0]          ll_s4, mm_s4;
	logic                     ypos_s4, degen_s4;
	logic [PROD_W-1:0]        lp_s5, tt_s5;
	logic [SQ_W-1:0]          mq_s5 [4];
	logic [SQ_W-1:0]          ll_s5;
	logic                     ypos_s5, degen_s5;
	logic [WORD_BITS-2:0]     r_s1, r_s2, r_s3, r_s4, r_s5;
	div_t                     dx_s6, dy_s6;

	logic signed [SQ_W+1:0] psum, lsum, tsum, tabs;
	logic [SQ_W-1:0]        rest, mm;
	logic                   tge;
	logic [PROD_W-1:0]      qq, msq;
	logic [NUM_W-1:0]       nx, ny;

	always_comb begin
		psum = (SQ_W+2)'(pp_s2[0]) + (SQ_W+2)'(pp_s2[1]) + (SQ_W+2)'(pp_s2[2]);
		lsum = (SQ_W+2)'(ll_s2[0]) + (SQ_W+2)'(ll_s2[1]) + (SQ_W+2)'(ll_s2[2]);
		tsum = (SQ_W+2)'(pb_s2[0]) + (SQ_W+2)'(pb_s2[1]) + (SQ_W+2)'(pb_s2[2]);
		tabs = tsum[SQ_W+1] ? -tsum : tsum;
		// axial excess magnitude before scaling
		tge  = (tm_s3 >= ll_s3);
		rest = ll_s3 - tm_s3;
		if (tneg_s3)
			mm = tm_s3;
		else if (tge)
			mm = tm_s3 - ll_s3;
		else
			mm = (tm_s3 < rest) ? tm_s3 : rest;
		qq  = lp_s5 - tt_s5;
		msq = sum4(mq_s5[0], mq_s5[1], mq_s5[2], mq_s5[3]);
		nx  = {qq, {(2*GUARD_BITS){1'b0}}};
		ny  = {msq, {(2*GUARD_BITS){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= {px[i][WORD_BITS-1], px[i]} - {ax[i][WORD_BITS-1], ax[i]};
				ba_s1[i] <= {bx[i][WORD_BITS-1], bx[i]} - {ax[i][WORD_BITS-1], ax[i]};
				pp_s2[i] <= pa_s1[i] * pa_s1[i];
				ll_s2[i] <= ba_s1[i] * ba_s1[i];
				pb_s2[i] <= pa_s1[i] * ba_s1[i];
			end
			r_s1 <= in_data.radius;
			r_s2 <= r_s1;
			pp_s3   <= psum[SQ_W-1:0];
			ll_s3   <= lsum[SQ_W-1:0];
			tm_s3   <= tabs[SQ_W-1:0];
			tneg_s3 <= tsum[SQ_W+1];
			r_s3    <= r_s2;
			lp_s4[0] <= ll_s3[SQ_W-1:HALF_W] * pp_s3[SQ_W-1:HALF_W];
			lp_s4[1] <= ll_s3[SQ_W-1:HALF_W] * pp_s3[HALF_W-1:0];
			lp_s4[2] <= ll_s3[HALF_W-1:0] * pp_s3[SQ_W-1:HALF_W];
			lp_s4[3] <= ll_s3[HALF_W-1:0] * pp_s3[HALF_W-1:0];
			tt_s4[0] <= tm_s3[SQ_W-1:HALF_W] * tm_s3[SQ_W-1:HALF_W];
			tt_s4[1] <= tm_s3[SQ_W-1:HALF_W] * tm_s3[HALF_W-1:0];
			tt_s4[2] <= tm_s3[HALF_W-1:0] * tm_s3[SQ_W-1:HALF_W];
			tt_s4[3] <= tm_s3[HALF_W-1:0] * tm_s3[HALF_W-1:0];
			ll_s4    <= ll_s3;
			mm_s4    <= mm;
			ypos_s4  <= tneg_s3 || tge;
			degen_s4 <= (ll_s3 == '0);
			r_s4     <= r_s3;
			lp_s5 <= sum4(lp_s4[0], lp_s4[1], lp_s4[2], lp_s4[3]);
			tt_s5 <= sum4(tt_s4[0], tt_s4[1], tt_s4[2], tt_s4[3]);
			mq_s5[0] <= mm_s4[SQ_W-1:HALF_W] * mm_s4[SQ_W-1:HALF_W];
			mq_s5[1] <= mm_s4[SQ_W-1:HALF_W] * mm_s4[HALF_W-1:0];
			mq_s5[2] <= mm_s4[HALF_W-1:0] * mm_s4[SQ_W-1:HALF_W];
			mq_s5[3] <= mm_s4[HALF_W-1:0] * mm_s4[HALF_W-1:0];
			ll_s5    <= ll_s4;
			ypos_s5  <= ypos_s4;
			degen_s5 <= degen_s4;
			r_s5     <= r_s4;
			dx_s6.rem <= nx[NUM_W-1:QUO_W];
			dx_s6.w   <= nx[QUO_W-1:0];
			dx_s6.d   <= ll_s5;
			dy_s6.rem <= ny[NUM_W-1:QUO_W];
			dy_s6.w   <= ny[QUO_W-1:0];
			dy_s6.d   <= ll_s5;
		end
	end

	// ---------------- divider and root rows ----------------
	div_t  dxw [QUO_W+1], dyw [QUO_W+1];
	sqrt_t sxw [ROOT_W+1], syw [ROOT_W+1], sfw [ROOT_W+1];
	sida_t sa_q [SIDE_A_LEN];
	sidb_t sb_q [ROOT_W+1];
	sidb_t sc_q;
	logic [ROOT_W-1:0] xs_q, ys_q;
	sqrt_t sf_q;

	assign dxw[0] = dx_s6;
	assign dyw[0] = dy_s6;
	assign sxw[0] = '{rem: '0, root: '0, w: {{(RAD_W-QUO_W){1'b0}}, dxw[QUO_W].w}};
	assign syw[0] = '{rem: '0, root: '0, w: {{(RAD_W-QUO_W){1'b0}}, dyw[QUO_W].w}};
	assign sfw[0] = sf_q;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		ccsd_div_cell u_x (.clk(clk), .en(en), .din(dxw[k]), .dout(dxw[k+1]));
		ccsd_div_cell u_y (.clk(clk), .en(en), .din(dyw[k]), .dout(dyw[k+1]));
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		ccsd_sqrt_cell u_x (.clk(clk), .en(en), .din(sxw[k]), .dout(sxw[k+1]));
		ccsd_sqrt_cell u_y (.clk(clk), .en(en), .din(syw[k]), .dout(syw[k+1]));
		ccsd_sqrt_cell u_f (.clk(clk), .en(en), .din(sfw[k]), .dout(sfw[k+1]));
	end

	// ---------------- radial/axial combine ----------------
	sida_t sal;
	logic signed [DIST_W-1:0] x4, y4, ymag;
	assign sal  = sa_q[SIDE_A_LEN-1];
	assign ymag = $signed({2'b00, syw[ROOT_W].root});
	assign x4   = $signed({2'b00, sxw[ROOT_W].root})
		- $signed({{(DIST_W-WORD_BITS+1-GUARD_BITS){1'b0}}, sal.radius, {GUARD_BITS{1'b0}}});
	assign y4   = sal.ypos ? ymag : -ymag;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_q[0] <= '{radius: r_s5, ypos: ypos_s5, degen: degen_s5};
			for (int k = 1; k < SIDE_A_LEN; k++)
				sa_q[k] <= sa_q[k-1];
			xs_q <= x4[DIST_W-1] ? '0 : x4[ROOT_W-1:0];
			ys_q <= y4[DIST_W-1] ? '0 : y4[ROOT_W-1:0];
			sc_q.bneg  <= x4[DIST_W-1] && y4[DIST_W-1];
			sc_q.dmax  <= (x4 > y4) ? x4 : y4;
			sc_q.degen <= sal.degen;
			sf_q.rem  <= '0;
			sf_q.root <= '0;
			sf_q.w    <= RAD_W'(xs_q * xs_q) + RAD_W'(ys_q * ys_q);
			sb_q[0]   <= sc_q;
			for (int k = 1; k <= ROOT_W; k++)
				sb_q[k] <= sb_q[k-1];
		end
	end

	// ---------------- rounding and clamp ----------------
	sidb_t sbl;
	logic signed [DIST_W-1:0] d4;
	logic signed [DIST_W:0]   v4, qv;
	assign sbl = sb_q[ROOT_W];

	always_comb begin
		d4 = sbl.bneg ? sbl.dmax : $signed({2'b00, sfw[ROOT_W].root});
		v4 = (DIST_W+1)'(d4) + (DIST_W+1)'(2**(GUARD_BITS-1));
		qv = v4 >>> GUARD_BITS;
		res.degenerate = 1'b0;
		if (sbl.degen) begin
			res.distance   = '0;
			res.degenerate = 1'b1;
			res.saturated  = 1'b0;
		end else if (qv > D_HI) begin
			res.distance  = D_HI[WORD_BITS-1:0];
			res.saturated = 1'b1;
		end else if (qv < D_LO) begin
			res.distance  = D_LO[WORD_BITS-1:0];
			res.saturated = 1'b1;
		end else begin
			res.distance  = qv[WORD_BITS-1:0];
			res.saturated = 1'b0;
		end
	end

	// ---------------- valid line and output/skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ov_q  <= 1'b0;
			sv_q  <= 1'b0;
		end else begin
			if (en)
				vld_q <= {vld_q[N_STAGES-2:0], in_valid};
			if (sv_q) begin
				if (out_ready)
					sv_q <= 1'b0;
			end else if (!ov_q || out_ready) begin
				ov_q <= vld_q[N_STAGES-1];
			end else if (vld_q[N_STAGES-1]) begin
				sv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (out_ready)
				oq_q <= sq_q;
		end else if (!ov_q || out_ready) begin
			if (vld_q[N_STAGES-1])
				oq_q <= res;
		end else if (vld_q[N_STAGES-1]) begin
			sq_q <= res;
		end
	end

	// ---------------- checks ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid register full while output register empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted transaction missing from first stage");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.degenerate) |-> (out_data.distance == '0 && !out_data.saturated))
		else $error("degenerate result with nonzero distance");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated) |->
		(out_data.distance == D_HI[WORD_BITS-1:0] || out_data.distance == D_LO[WORD_BITS-1:0]))
		else $error("saturated result not at a range limit");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |=> $stable(vld_q) || !$past(sv_q))
		else $error("pipeline advanced while skid register full");

endmodule
`default_nettype wire
